[rtl/nic_pkg.sv]
// Shared codes for the nibble instruction core: actions, opcodes, status codes.
// No dependencies.
package nic_pkg;

   localparam logic [2:0] ACT_WRITE = 3'd0;
   localparam logic [2:0] ACT_READ  = 3'd1;
   localparam logic [2:0] ACT_REG   = 3'd2;
   localparam logic [2:0] ACT_POWER = 3'd3;
   localparam logic [2:0] ACT_STEP  = 3'd4;

   localparam logic [3:0] OP_EXT = 4'h0;
   localparam logic [3:0] OP_MOV = 4'h1;
   localparam logic [3:0] OP_LDI = 4'h2;
   localparam logic [3:0] OP_ADD = 4'h3;
   localparam logic [3:0] OP_SUB = 4'h4;
   localparam logic [3:0] OP_MUL = 4'h5;
   localparam logic [3:0] OP_DIV = 4'h6;

   localparam logic [3:0] EXT_NOP  = 4'h0;
   localparam logic [3:0] EXT_HALT = 4'h1;
   localparam logic [3:0] EXT_JMP  = 4'h2;
   localparam logic [3:0] EXT_JEQ  = 4'h3;
   localparam logic [3:0] EXT_JNE  = 4'h4;
   localparam logic [3:0] EXT_JC   = 4'h5;
   localparam logic [3:0] EXT_JNC  = 4'h6;
   localparam logic [3:0] EXT_JS   = 4'h7;
   localparam logic [3:0] EXT_JNS  = 4'h8;
   localparam logic [3:0] EXT_JO   = 4'h9;
   localparam logic [3:0] EXT_JNO  = 4'hA;
   localparam logic [3:0] EXT_JLT  = 4'hB;
   localparam logic [3:0] EXT_JGT  = 4'hC;
   localparam logic [3:0] EXT_LD   = 4'hD;
   localparam logic [3:0] EXT_ST   = 4'hE;

   localparam logic [2:0] ST_OK     = 3'd0;
   localparam logic [2:0] ST_HALT   = 3'd1;
   localparam logic [2:0] ST_PC     = 3'd2;
   localparam logic [2:0] ST_LDI    = 3'd3;
   localparam logic [2:0] ST_BADOP  = 3'd4;
   localparam logic [2:0] ST_DIV0   = 3'd5;
   localparam logic [2:0] ST_LIMIT  = 3'd6;

   localparam logic [4:0] REG_FLAGS = 5'd16;

endpackage

[rtl/nic_ram.sv]
// Generic single-port RAM with registered read data.
// No dependencies.
module nic_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end

endmodule

[rtl/nibble_isa_cpu_core.sv]
// Top level of the nibble instruction core: sequencer, shared adder, divider loop.
// Depends on nic_pkg and nic_ram.
//
// After reset the core sweeps its byte memory to zero, one byte a cycle, with
// busy high. An item is taken when start is high and busy low; busy then stays
// high until the result strobe rsp_valid, which lasts one cycle and cannot be
// held off. Byte writes, power toggles, flag reads and reads of a register
// index above 16 go straight to the strobe; byte and register reads pass a read
// state first, and a step that stops before the fetch (core off, step limit, pc
// out of memory) its check state. Most instructions fetch two bytes and do two
// register-file reads through single ports; ldi then loads four bytes, the
// 16-bit load two, the 16-bit store writes its second byte, mul writes back,
// and div runs a 32-iteration restoring divider on the shared adder. MEM_BYTES
// must be a power of two; addresses wrap at it.
module nibble_isa_cpu_core
   import nic_pkg::*;
#(
   parameter int MEM_BYTES = 65536
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_action,
   input  logic [15:0] req_address,
   input  logic [7:0]  req_data,
   input  logic [4:0]  req_reg_index,
   output logic        rsp_valid,
   output logic [31:0] rsp_read_value,
   output logic [31:0] rsp_prog_counter,
   output logic        rsp_running,
   output logic [2:0]  rsp_status,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_data
);

   localparam int AW = $clog2(MEM_BYTES);
   localparam logic [32:0] MEM_SIZE = 33'(MEM_BYTES);
   localparam logic [AW-1:0] CLR_LAST = AW'(MEM_BYTES - 1);

   localparam logic [3:0] S_CLR  = 4'd0;
   localparam logic [3:0] S_IDLE = 4'd1;
   localparam logic [3:0] S_MRD  = 4'd2;
   localparam logic [3:0] S_RRD  = 4'd3;
   localparam logic [3:0] S_STEP = 4'd4;
   localparam logic [3:0] S_FLO  = 4'd5;
   localparam logic [3:0] S_FDEC = 4'd6;
   localparam logic [3:0] S_FRA  = 4'd7;
   localparam logic [3:0] S_FRB  = 4'd8;
   localparam logic [3:0] S_EXE  = 4'd9;
   localparam logic [3:0] S_LDI  = 4'd10;
   localparam logic [3:0] S_LD   = 4'd11;
   localparam logic [3:0] S_ST2  = 4'd12;
   localparam logic [3:0] S_DIV  = 4'd13;
   localparam logic [3:0] S_WB   = 4'd14;
   localparam logic [3:0] S_FIN  = 4'd15;

   logic [3:0]    state_ff, state_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic [31:0]   pc_ff, pc_in;
   logic [3:0]    flags_ff, flags_in;
   logic          run_ff, run_in;
   logic [31:0]   steps_ff, steps_in;
   logic [31:0]   limit_ff;
   logic [15:0]   ins_ff, ins_in;
   logic [31:0]   va_ff, va_in;
   logic [31:0]   vb_ff, vb_in;
   logic [31:0]   acc_ff, acc_in;
   logic [31:0]   rem_ff, rem_in;
   logic [5:0]    cnt_ff, cnt_in;
   logic [31:0]   rv_ff, rv_in;
   logic [2:0]    st_ff, st_in;
   logic [15:0]   rf_vld_ff, rf_vld_in;
   logic [3:0]    rf_idx_ff;

   logic          mem_we;
   logic [AW-1:0] mem_addr;
   logic [7:0]    mem_wdata, mem_q;
   logic          rf_we;
   logic [3:0]    rf_addr;
   logic [31:0]   rf_wdata, rf_q, rf_val;

   logic [32:0]   alu_x, alu_y, alu_res;
   logic          alu_sub;
   logic [31:0]   prod;
   logic [32:0]   rem_sh;
   logic [31:0]   addr_ext;
   logic          take;
   logic          fz, fs, fc, fo;

   nic_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_mem (
      .clock(clock), .we(mem_we), .addr(mem_addr), .wdata(mem_wdata), .rdata(mem_q)
   );

   nic_ram #(.WIDTH(32), .DEPTH(16)) u_rf (
      .clock(clock), .we(rf_we), .addr(rf_addr), .wdata(rf_wdata), .rdata(rf_q)
   );

   // Entries never written since reset read as zero.
   assign rf_val   = rf_vld_ff[rf_idx_ff] ? rf_q : 32'd0;
   assign alu_res  = alu_sub ? (alu_x - alu_y) : (alu_x + alu_y);
   assign prod     = va_ff * vb_ff;
   assign rem_sh   = {rem_ff, acc_ff[31]};
   assign addr_ext = {16'd0, req_address};
   assign {fo, fs, fz, fc} = flags_ff;

   always_comb begin
      case (ins_ff[11:8])
         EXT_JMP: take = 1'b1;
         EXT_JEQ: take = fz;
         EXT_JNE: take = !fz;
         EXT_JC:  take = fc;
         EXT_JNC: take = !fc;
         EXT_JS:  take = fs;
         EXT_JNS: take = !fs;
         EXT_JO:  take = fo;
         EXT_JNO: take = !fo;
         EXT_JLT: take = fs != fo;
         EXT_JGT: take = !fz && (fs == fo);
         default: take = 1'b0;
      endcase
   end

   always_comb begin
      state_in  = state_ff;
      clr_in    = clr_ff;
      pc_in     = pc_ff;
      flags_in  = flags_ff;
      run_in    = run_ff;
      steps_in  = steps_ff;
      ins_in    = ins_ff;
      va_in     = va_ff;
      vb_in     = vb_ff;
      acc_in    = acc_ff;
      rem_in    = rem_ff;
      cnt_in    = cnt_ff;
      rv_in     = rv_ff;
      st_in     = st_ff;
      rf_vld_in = rf_vld_ff;
      mem_we    = 1'b0;
      mem_addr  = pc_ff[AW-1:0];
      mem_wdata = 8'd0;
      rf_we     = 1'b0;
      rf_addr   = ins_ff[11:8];
      rf_wdata  = acc_ff;
      alu_sub   = 1'b0;
      alu_x     = {1'b0, va_ff};
      alu_y     = {1'b0, vb_ff};

      case (state_ff)
         S_CLR: begin
            mem_we   = 1'b1;
            mem_addr = clr_ff;
            clr_in   = clr_ff + AW'(1);
            if (clr_ff == CLR_LAST) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               rv_in    = 32'd0;
               st_in    = ST_OK;
               state_in = S_FIN;
               mem_addr = addr_ext[AW-1:0];
               rf_addr  = req_reg_index[3:0];
               case (req_action)
                  ACT_WRITE: begin
                     mem_we    = 1'b1;
                     mem_wdata = req_data;
                  end
                  ACT_READ: state_in = S_MRD;
                  ACT_REG: begin
                     if (req_reg_index < REG_FLAGS) begin
                        state_in = S_RRD;
                     end else if (req_reg_index == REG_FLAGS) begin
                        rv_in = {28'd0, flags_ff};
                     end
                  end
                  ACT_POWER: begin
                     run_in = !run_ff;
                     if (!run_ff) begin
                        steps_in = 32'd0;
                     end
                  end
                  ACT_STEP: state_in = S_STEP;
                  default: state_in = S_FIN;
               endcase
            end
         end
         S_MRD: begin
            rv_in    = {24'd0, mem_q};
            state_in = S_FIN;
         end
         S_RRD: begin
            rv_in    = rf_val;
            state_in = S_FIN;
         end
         S_STEP: begin
            state_in = S_FIN;
            if (run_ff) begin
               if (limit_ff != 32'd0 && steps_ff >= limit_ff) begin
                  run_in = 1'b0;
                  st_in  = ST_LIMIT;
               end else begin
                  steps_in = steps_ff + 32'd1;
                  if ({1'b0, pc_ff} + 33'd1 >= MEM_SIZE) begin
                     run_in = 1'b0;
                     st_in  = ST_PC;
                  end else begin
                     state_in = S_FLO;
                  end
               end
            end
         end
         S_FLO: begin
            mem_addr = pc_ff[AW-1:0] + AW'(1);
            ins_in   = {mem_q, 8'd0};
            state_in = S_FDEC;
         end
         S_FDEC: begin
            ins_in   = {ins_ff[15:8], mem_q};
            pc_in    = pc_ff + 32'd2;
            rf_addr  = mem_q[7:4];
            state_in = S_FRA;
         end
         S_FRA: begin
            va_in    = rf_val;
            rf_addr  = ins_ff[3:0];
            state_in = S_FRB;
         end
         S_FRB: begin
            vb_in    = rf_val;
            cnt_in   = 6'd0;
            state_in = S_EXE;
         end
         S_EXE: begin
            state_in = S_FIN;
            case (ins_ff[15:12])
               OP_EXT: begin
                  case (ins_ff[11:8])
                     EXT_NOP: state_in = S_FIN;
                     EXT_HALT: begin
                        run_in = 1'b0;
                        st_in  = ST_HALT;
                     end
                     EXT_LD: state_in = S_LD;
                     EXT_ST: begin
                        mem_we    = 1'b1;
                        mem_addr  = va_ff[AW-1:0];
                        mem_wdata = vb_ff[15:8];
                        state_in  = S_ST2;
                     end
                     4'hF: begin
                        run_in = 1'b0;
                        st_in  = ST_BADOP;
                     end
                     default: begin
                        if (take) begin
                           pc_in = va_ff;
                        end
                     end
                  endcase
               end
               OP_MOV: begin
                  rf_we    = 1'b1;
                  rf_wdata = {24'd0, ins_ff[7:0]};
               end
               OP_LDI: begin
                  if ({1'b0, pc_ff} + 33'd4 > MEM_SIZE) begin
                     run_in = 1'b0;
                     st_in  = ST_LDI;
                  end else begin
                     state_in = S_LDI;
                  end
               end
               OP_ADD, OP_SUB: begin
                  alu_sub  = ins_ff[14];
                  rf_we    = 1'b1;
                  rf_wdata = alu_res[31:0];
                  flags_in[2] = alu_res[31];
                  flags_in[1] = alu_res[31:0] == 32'd0;
                  // add: carry out; sub: borrow shows in bit 32 of the difference
                  flags_in[0] = alu_res[32];
                  if (ins_ff[14]) begin
                     flags_in[3] = (va_ff[31] ^ vb_ff[31]) & (va_ff[31] ^ alu_res[31]);
                  end else begin
                     flags_in[3] = (va_ff[31] ^ alu_res[31]) & (vb_ff[31] ^ alu_res[31]);
                  end
               end
               OP_MUL: begin
                  acc_in   = prod;
                  state_in = S_WB;
               end
               OP_DIV: begin
                  if (vb_ff == 32'd0) begin
                     run_in = 1'b0;
                     st_in  = ST_DIV0;
                  end else begin
                     acc_in   = va_ff;
                     rem_in   = 32'd0;
                     state_in = S_DIV;
                  end
               end
               default: begin
                  run_in = 1'b0;
                  st_in  = ST_BADOP;
               end
            endcase
         end
         S_LDI: begin
            // issue bytes pc..pc+3, shift each in the cycle after it is issued
            mem_addr = pc_ff[AW-1:0] + AW'(cnt_ff[1:0]);
            cnt_in   = cnt_ff + 6'd1;
            if (cnt_ff != 6'd0) begin
               acc_in = {acc_ff[23:0], mem_q};
            end
            if (cnt_ff == 6'd4) begin
               rf_we    = 1'b1;
               rf_wdata = {acc_ff[23:0], mem_q};
               pc_in    = pc_ff + 32'd4;
               state_in = S_FIN;
            end
         end
         S_LD: begin
            mem_addr = vb_ff[AW-1:0] + AW'(cnt_ff[0]);
            cnt_in   = cnt_ff + 6'd1;
            if (cnt_ff != 6'd0) begin
               acc_in = {acc_ff[23:0], mem_q};
            end
            if (cnt_ff == 6'd2) begin
               rf_we    = 1'b1;
               rf_addr  = ins_ff[7:4];
               rf_wdata = {16'd0, acc_ff[7:0], mem_q};
               state_in = S_FIN;
            end
         end
         S_ST2: begin
            mem_we    = 1'b1;
            mem_addr  = va_ff[AW-1:0] + AW'(1);
            mem_wdata = vb_ff[7:0];
            state_in  = S_FIN;
         end
         S_DIV: begin
            alu_sub = 1'b1;
            alu_x   = rem_sh;
            alu_y   = {1'b0, vb_ff};
            cnt_in  = cnt_ff + 6'd1;
            if (alu_res[32]) begin
               rem_in = rem_sh[31:0];
               acc_in = {acc_ff[30:0], 1'b0};
            end else begin
               rem_in = alu_res[31:0];
               acc_in = {acc_ff[30:0], 1'b1};
            end
            if (cnt_ff == 6'd31) begin
               state_in = S_WB;
            end
         end
         S_WB: begin
            rf_we    = 1'b1;
            flags_in = {2'b00, acc_ff == 32'd0, 1'b0} | {1'b0, acc_ff[31], 2'b00};
            state_in = S_FIN;
         end
         S_FIN: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase

      if (rf_we) begin
         rf_vld_in[rf_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_CLR;
         clr_ff    <= '0;
         pc_ff     <= 32'd0;
         flags_ff  <= 4'd0;
         run_ff    <= 1'b0;
         steps_ff  <= 32'd0;
         limit_ff  <= 32'd50000;
         rf_vld_ff <= 16'd0;
         rv_ff     <= 32'd0;
         st_ff     <= ST_OK;
      end else begin
         state_ff  <= state_in;
         clr_ff    <= clr_in;
         pc_ff     <= pc_in;
         flags_ff  <= flags_in;
         run_ff    <= run_in;
         steps_ff  <= steps_in;
         rf_vld_ff <= rf_vld_in;
         rv_ff     <= rv_in;
         st_ff     <= st_in;
         if (csr_valid) begin
            limit_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      ins_ff    <= ins_in;
      va_ff     <= va_in;
      vb_ff     <= vb_in;
      acc_ff    <= acc_in;
      rem_ff    <= rem_in;
      cnt_ff    <= cnt_in;
      rf_idx_ff <= rf_addr;
   end

   assign busy             = state_ff != S_IDLE;
   assign csr_ready        = 1'b1;
   assign rsp_valid        = state_ff == S_FIN;
   assign rsp_read_value   = rv_ff;
   assign rsp_prog_counter = pc_ff;
   assign rsp_running      = run_ff;
   assign rsp_status       = st_ff;

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("accepted item did not raise busy");

   a_fault_stops: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> !rsp_running)
      else $error("nonzero status while running");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result strobe longer than one cycle");

   a_pc_steady: assert property (@(posedge clock) disable iff (reset)
      !busy && $past(!busy) |-> $stable(rsp_prog_counter))
      else $error("pc moved while idle");

endmodule
